// ----- rtl/wamf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wamf_pkg: shared types and constants of the windowed forecast unit
// reset values, register indexes, command codes and state encodings
// ----------------------------------------------------------------------------
package wamf_pkg;

    localparam int DEF_MAX_FACTORS = 8;
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 32;
    localparam int FRAC_BITS       = 24;
    localparam int RESULT_LIMIT    = 8;
    localparam int AR_MIN_SAMPLES  = 5;
    localparam int MOM_MIN_SAMPLES = 2;

    localparam logic [6:0]  WINDOW_RESET = 7'd60;
    localparam logic [3:0]  FACTORS_RESET = 4'd3;
    localparam logic [15:0] WEIGHT_RESET = 16'd22938;
    localparam logic [16:0] WEIGHT_ONE = 17'd32768;

    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_FACTORS = 2'd1;
    localparam logic [1:0] REG_WEIGHT  = 2'd2;

    localparam logic CMD_PUSH     = 1'b0;
    localparam logic CMD_FORECAST = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_READ,
        ST_ACCUM,
        ST_MULT,
        ST_DIV_B,
        ST_PRED,
        ST_DIV_P,
        ST_BLEND,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/wamf_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wamf_divider: unsigned restoring divider
// one quotient bit per cycle; remainder kept internally, quotient output for a wide operand pair
// ----------------------------------------------------------------------------
module wamf_divider #(
    parameter int WIDTH = 160
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH:0]   rem_reg, rem_next;
    logic [WIDTH-1:0] div_reg, div_next;
    logic [WIDTH:0]   shifted;

    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        shifted    = {rem_reg[WIDTH-1:0], quo_reg[WIDTH-1]};
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CW'(WIDTH);
            quo_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next    = shifted - {1'b0, div_reg};
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = shifted;
            end
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("divider not busy after start");
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> count_reg != '0)
        else $error("divider count underflow");

endmodule

// ----- rtl/wamf_history.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wamf_history: return history memory
// one ring per factor, synchronous write and registered read
// ----------------------------------------------------------------------------
module wamf_history #(
    parameter int DEPTH = 512,
    parameter int DW    = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/windowed_ar1_momentum_forecast_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_ar1_momentum_forecast_unit: per-factor AR(1) and momentum forecast
// sliding windows of returns kept in one memory, forecasts computed serially
// ----------------------------------------------------------------------------
// A push transaction performs one memory write. A forecast walks each active
// factor's window through the history memory, one entry per cycle, then runs
// up to two serial divisions of 160 bits each, one quotient bit per cycle:
// none when the window holds fewer than five returns, one when the slope
// denominator is not positive. A result that waits on a stalled output holds
// the sequencer. No item is accepted while a transaction is in progress.
// Memory contents are undefined after reset; only pushed entries are used.
module windowed_ar1_momentum_forecast_unit #(
    parameter int MAX_FACTORS = wamf_pkg::DEF_MAX_FACTORS,
    parameter int MAX_WINDOW  = wamf_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = wamf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   command,
    input  logic [2:0]             factor_sel,
    input  logic [SAMPLE_BITS-1:0] sample_return,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             factor_id,
    output logic [31:0]            ar1_prediction,
    output logic [1:0]             momentum_sign,
    output logic [31:0]            blended_prediction,
    output logic                   last_of_run
);

    localparam int FW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
    localparam int PW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int AW = $clog2(MAX_FACTORS * MAX_WINDOW);
    localparam int SW = SAMPLE_BITS + PW + 1;
    localparam int QW = 2 * SAMPLE_BITS + PW + 1;
    localparam int DW = 160;

    logic [6:0]  win_reg;
    logic [3:0]  fcnt_reg;
    logic [15:0] wgt_reg;

    logic [CW-1:0] fill_reg [MAX_FACTORS];
    logic [PW-1:0] wptr_reg [MAX_FACTORS];

    wamf_pkg::state_t state_reg, state_next;

    logic [FW-1:0]           f_reg;
    logic [3:0]              fc_reg;
    logic [CW-1:0]           c_reg;
    logic [CW:0]             rd_cnt_reg;
    logic [CW:0]             acc_cnt_reg;
    logic [SAMPLE_BITS-1:0]  prev_reg;
    logic signed [SW-1:0]    sx_reg, sy_reg, sum_reg;
    logic signed [QW-1:0]    sxx_reg, sxy_reg;
    logic signed [SAMPLE_BITS-1:0] last_reg;
    logic signed [DW-1:0]    num_reg, den_reg;
    logic signed [31:0]      b_reg, ar_reg, bl_reg;
    logic signed [1:0]       mom_reg;
    logic                    neg_reg;
    logic [1:0]              mstep_reg;
    logic                    last_run_reg;
    logic                    out_valid_reg;
    logic                    div_phase_reg;

    logic [CW-1:0]  eff_win;
    logic [CW-1:0]  c_sel;
    logic [3:0]     fc_eff;
    logic [16:0]    w_eff;
    logic           accept_in;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [SAMPLE_BITS-1:0] mem_rdata;

    logic           div_start;
    logic           div_busy;
    logic           div_done;
    logic [DW-1:0]  div_a, div_b, div_q;

    always_comb
    begin
        if (win_reg < 7'd2)
            eff_win = CW'(2);
        else if (32'(win_reg) > MAX_WINDOW)
            eff_win = CW'(MAX_WINDOW);
        else
            eff_win = CW'(win_reg);
        if (fcnt_reg == 4'd0)
            fc_eff = 4'd1;
        else if (32'(fcnt_reg) > MAX_FACTORS)
            fc_eff = 4'(MAX_FACTORS);
        else
            fc_eff = fcnt_reg;
        if (fc_eff > 4'(wamf_pkg::RESULT_LIMIT))
            fc_eff = 4'(wamf_pkg::RESULT_LIMIT);
        w_eff = ({1'b0, wgt_reg} > wamf_pkg::WEIGHT_ONE) ? wamf_pkg::WEIGHT_ONE
                                                         : {1'b0, wgt_reg};
        c_sel = (fill_reg[f_reg] < eff_win) ? fill_reg[f_reg] : eff_win;
    end

    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != wamf_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == wamf_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= wamf_pkg::WINDOW_RESET;
            fcnt_reg <= wamf_pkg::FACTORS_RESET;
            wgt_reg  <= wamf_pkg::WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wamf_pkg::REG_WINDOW:  win_reg  <= cfg_data[6:0];
                wamf_pkg::REG_FACTORS: fcnt_reg <= cfg_data[3:0];
                wamf_pkg::REG_WEIGHT:  wgt_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // window entry address: oldest entry first
    logic [PW-1:0] rd_slot;
    assign rd_slot   = PW'(wptr_reg[f_reg] - PW'(c_reg) + PW'(rd_cnt_reg));
    assign mem_raddr = AW'({f_reg, rd_slot});
    assign mem_we    = (state_reg == wamf_pkg::ST_PUSH);
    assign mem_waddr = AW'({f_reg, wptr_reg[f_reg]});

    wamf_history #(
        .DEPTH (MAX_FACTORS * MAX_WINDOW),
        .DW    (SAMPLE_BITS)
    ) u_history (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (prev_reg),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    wamf_divider #(
        .WIDTH (DW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wamf_pkg::ST_IDLE:
                if (accept_in)
                begin
                    if (command == wamf_pkg::CMD_PUSH)
                        state_next = (32'(factor_sel) < MAX_FACTORS) ? wamf_pkg::ST_PUSH
                                                                      : wamf_pkg::ST_IDLE;
                    else
                        state_next = wamf_pkg::ST_READ;
                end
            wamf_pkg::ST_PUSH:  state_next = wamf_pkg::ST_IDLE;
            wamf_pkg::ST_READ:  state_next = wamf_pkg::ST_ACCUM;
            wamf_pkg::ST_ACCUM:
                if (acc_cnt_reg >= (CW + 1)'(c_reg))
                    state_next = wamf_pkg::ST_MULT;
            wamf_pkg::ST_MULT:
                if (mstep_reg == 2'd3)
                begin
                    if (c_reg < CW'(wamf_pkg::AR_MIN_SAMPLES))
                        state_next = wamf_pkg::ST_BLEND;
                    else if (den_reg[DW-1] || den_reg == '0)
                        state_next = wamf_pkg::ST_PRED;
                    else
                        state_next = wamf_pkg::ST_DIV_B;
                end
            wamf_pkg::ST_DIV_B:
                if (div_done)
                    state_next = wamf_pkg::ST_PRED;
            wamf_pkg::ST_PRED:
                if (mstep_reg == 2'd3)
                    state_next = wamf_pkg::ST_DIV_P;
            wamf_pkg::ST_DIV_P:
                if (div_done)
                    state_next = wamf_pkg::ST_BLEND;
            wamf_pkg::ST_BLEND: state_next = wamf_pkg::ST_OUT;
            wamf_pkg::ST_OUT:
                if (out_valid_reg && !out_stall)
                    state_next = last_run_reg ? wamf_pkg::ST_IDLE : wamf_pkg::ST_READ;
            default: state_next = wamf_pkg::ST_IDLE;
        endcase
    end

    logic signed [CW:0] nn;
    assign nn = signed'({1'b0, CW'(c_reg - 1'b1)});

    logic signed [DW-1:0] tmp_reg;

    // divider operands
    logic signed [DW-1:0] p_val;
    logic [DW-1:0] num_abs, p_abs;
    logic [DW-1:0] n_shift;
    assign p_val   = num_reg + tmp_reg * nn;
    assign num_abs = num_reg[DW-1] ? DW'(-num_reg) : DW'(num_reg);
    assign p_abs   = p_val[DW-1] ? DW'(-p_val) : DW'(p_val);
    assign n_shift = DW'(c_reg - 1'b1) << wamf_pkg::FRAC_BITS;

    // outputs of the sequencer
    always_comb
    begin
        div_start = 1'b0;
        div_a = '0;
        div_b = '0;
        unique case (state_reg)
            wamf_pkg::ST_MULT:
                if (mstep_reg == 2'd3 && c_reg >= CW'(wamf_pkg::AR_MIN_SAMPLES))
                begin
                    div_start = !(den_reg[DW-1] || den_reg == '0);
                    div_a = num_abs << wamf_pkg::FRAC_BITS;
                    div_b = DW'(den_reg);
                end
            wamf_pkg::ST_PRED:
                if (mstep_reg == 2'd3)
                begin
                    div_start = 1'b1;
                    div_a = p_abs;
                    div_b = n_shift;
                end
            default: ;
        endcase
    end

    // quotients of b and of the prediction, saturated to 32-bit signed
    logic signed [31:0] b_sat, p_sat;
    always_comb
    begin
        if (neg_reg)
            b_sat = (div_q > DW'(33'h080000000)) ? 32'sh80000000 : 32'(-div_q);
        else
            b_sat = (div_q > DW'(32'h7fffffff)) ? 32'sh7fffffff : 32'(div_q);
        if (neg_reg)
            p_sat = (div_q > DW'(33'h080000000)) ? 32'sh80000000 : 32'(-div_q);
        else
            p_sat = (div_q > DW'(32'h7fffffff)) ? 32'sh7fffffff : 32'(div_q);
    end

    logic signed [SW-1:0] prod_a, prod_b;
    logic signed [2*SW-1:0] prod_r;
    logic signed [DW-1:0] prod_wide;
    always_comb
    begin
        prod_a = sx_reg;
        prod_b = sy_reg;
        unique case (state_reg)
            wamf_pkg::ST_MULT:
                unique case (mstep_reg)
                    2'd1:    prod_b = sx_reg;
                    default: prod_b = sy_reg;
                endcase
            wamf_pkg::ST_PRED:
                unique case (mstep_reg)
                    2'd1:    begin prod_a = SW'(b_reg); prod_b = sx_reg; end
                    2'd2:    begin prod_a = SW'(b_reg); prod_b = SW'(last_reg); end
                    default: prod_b = sy_reg;
                endcase
            default: ;
        endcase
        prod_r    = prod_a * prod_b;
        prod_wide = DW'(prod_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wamf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_FACTORS; i++)
            begin
                fill_reg[i] <= '0;
                wptr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == wamf_pkg::ST_PUSH)
            begin
                wptr_reg[f_reg] <= wptr_reg[f_reg] + 1'b1;
                fill_reg[f_reg] <= (fill_reg[f_reg] < eff_win) ? fill_reg[f_reg] + 1'b1
                                                              : eff_win;
            end
            if (state_reg == wamf_pkg::ST_BLEND)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    logic signed [49:0] blend_sum;
    logic signed [49:0] blend_q;
    assign blend_sum = 50'(signed'({1'b0, w_eff})) * 50'(ar_reg)
                     + 50'(signed'({1'b0, wamf_pkg::WEIGHT_ONE - w_eff}))
                       * (50'(mom_reg) <<< wamf_pkg::FRAC_BITS);
    assign blend_q = (blend_sum < 0) ? -((-blend_sum) >>> 15) : (blend_sum >>> 15);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            wamf_pkg::ST_IDLE:
                if (accept_in)
                begin
                    f_reg    <= (command == wamf_pkg::CMD_PUSH) ? FW'(factor_sel) : '0;
                    prev_reg <= sample_return;
                    fc_reg   <= fc_eff;
                end
            wamf_pkg::ST_READ:
            begin
                c_reg       <= c_sel;
                rd_cnt_reg  <= '0;
                acc_cnt_reg <= '0;
                sx_reg <= '0; sy_reg <= '0; sum_reg <= '0;
                sxx_reg <= '0; sxy_reg <= '0;
                mstep_reg <= '0;
            end
            wamf_pkg::ST_ACCUM:
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
                if (rd_cnt_reg != '0 && acc_cnt_reg < (CW + 1)'(c_reg))
                begin
                    acc_cnt_reg <= acc_cnt_reg + 1'b1;
                    sum_reg <= sum_reg + SW'(signed'(mem_rdata));
                    prev_reg <= mem_rdata;
                    last_reg <= signed'(mem_rdata);
                    if (acc_cnt_reg != '0)
                    begin
                        sx_reg  <= sx_reg + SW'(signed'(prev_reg));
                        sy_reg  <= sy_reg + SW'(signed'(mem_rdata));
                        sxx_reg <= sxx_reg + QW'(signed'(prev_reg) * signed'(prev_reg));
                        sxy_reg <= sxy_reg + QW'(signed'(prev_reg) * signed'(mem_rdata));
                    end
                end
            end
            wamf_pkg::ST_MULT:
            begin
                mstep_reg <= mstep_reg + 1'b1;
                unique case (mstep_reg)
                    2'd0: tmp_reg <= prod_wide;
                    2'd1: begin
                        num_reg <= DW'(sxy_reg) * nn - tmp_reg;
                        den_reg <= DW'(sxx_reg) * nn - prod_wide;
                    end
                    2'd2: neg_reg <= num_reg[DW-1];
                    default: b_reg <= '0;
                endcase
                if (c_reg >= CW'(wamf_pkg::MOM_MIN_SAMPLES))
                    mom_reg <= (sum_reg > 0) ? 2'sd1 : -2'sd1;
                else
                    mom_reg <= 2'sd0;
                ar_reg <= '0;
            end
            wamf_pkg::ST_DIV_B:
                if (div_done)
                begin
                    b_reg <= b_sat;
                    mstep_reg <= '0;
                end
            wamf_pkg::ST_PRED:
            begin
                mstep_reg <= mstep_reg + 1'b1;
                unique case (mstep_reg)
                    2'd0: num_reg <= DW'(sy_reg) <<< wamf_pkg::FRAC_BITS;
                    2'd1: num_reg <= num_reg - prod_wide;
                    2'd2: tmp_reg <= prod_wide;
                    default: ;
                endcase
                if (mstep_reg == 2'd3)
                begin
                    neg_reg <= p_val[DW-1];
                    num_reg <= p_val;
                end
            end
            wamf_pkg::ST_DIV_P:
                if (div_done)
                    ar_reg <= p_sat;
            wamf_pkg::ST_BLEND:
            begin
                if (blend_q > 50'sd2147483647)
                    bl_reg <= 32'sh7fffffff;
                else if (blend_q < -50'sd2147483648)
                    bl_reg <= 32'sh80000000;
                else
                    bl_reg <= 32'(blend_q);
                last_run_reg <= (4'(f_reg) + 4'd1 == fc_reg);
            end
            wamf_pkg::ST_OUT:
                if (out_valid_reg && !out_stall)
                    f_reg <= f_reg + 1'b1;
            default: ;
        endcase
    end

    // window reads run on past the window end to absorb the registered memory read; that data is discarded
    assign out_valid          = out_valid_reg;
    assign factor_id          = 3'(f_reg);
    assign ar1_prediction     = ar_reg;
    assign momentum_sign      = mom_reg;
    assign blended_prediction = bl_reg;
    assign last_of_run        = last_run_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == wamf_pkg::ST_OUT)
        else $error("result shown outside output state");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wamf_pkg::ST_PUSH |=> state_reg == wamf_pkg::ST_IDLE)
        else $error("push longer than one cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(ar_reg) && $stable(bl_reg))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule

// ----- dv/tb_windowed_ar1_momentum_forecast_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_ar1_momentum_forecast_unit: self-checking bench of the forecaster
// pushes returns into per-factor windows and requests forecasts under several
// register settings and idle patterns; a scoreboard predicts every forecast
// bit for bit in wide integer arithmetic and compares each output transaction
// ----------------------------------------------------------------------------
module tb_windowed_ar1_momentum_forecast_unit;

    typedef struct {
        bit [2:0]  factor_id;
        bit [31:0] ar1_prediction;
        bit [1:0]  momentum_sign;
        bit [31:0] blended_prediction;
        bit        last_of_run;
    } forecast_t;

    class forecast_scoreboard;
        longint    history[8][64];
        int        fill[8];
        int        wptr[8];
        int        window_length;
        int        factor_count;
        int        blend_weight;
        forecast_t pending_q[$];
        int        mismatches;
        int        pushes;
        int        results;

        function new();
            for (int f = 0; f < 8; f++)
            begin
                fill[f] = 0;
                wptr[f] = 0;
            end
            window_length = wamf_pkg::WINDOW_RESET;
            factor_count  = wamf_pkg::FACTORS_RESET;
            blend_weight  = wamf_pkg::WEIGHT_RESET;
            mismatches    = 0;
            pushes        = 0;
            results       = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [15:0] data);
            if (idx == wamf_pkg::REG_WINDOW)
                window_length = data[6:0];
            else if (idx == wamf_pkg::REG_FACTORS)
                factor_count = data[3:0];
            else if (idx == wamf_pkg::REG_WEIGHT)
                blend_weight = data;
        endfunction

        function longint clip32(logic signed [159:0] v);
            if (v > 160'sd2147483647)
                return 64'sd2147483647;
            if (v < -160'sd2147483648)
                return -64'sd2147483648;
            return longint'(v);
        endfunction

        function longint sample_at(int f, int c, int i);
            return history[f][(wptr[f] + 64 - c + i) % 64];
        endfunction

        function longint ar1_forecast(int f, int c);
            logic signed [159:0] sx, sy, sxx, sxy, x, y, nn, num, den, b, last, p, one24;
            if (c < wamf_pkg::AR_MIN_SAMPLES)
                return 0;
            sx = 0; sy = 0; sxx = 0; sxy = 0;
            one24 = 160'sd16777216;
            for (int t = 1; t < c; t++)
            begin
                x = sample_at(f, c, t - 1);
                y = sample_at(f, c, t);
                sx = sx + x;
                sy = sy + y;
                sxx = sxx + x * x;
                sxy = sxy + x * y;
            end
            last = sample_at(f, c, c - 1);
            nn = c - 1;
            num = nn * sxy - sx * sy;
            den = nn * sxx - sx * sx;
            if (den <= 0)
                b = 0;
            else
                b = clip32(num * one24 / den);
            p = sy * one24 - b * sx + nn * b * last;
            return clip32(p / (nn * one24));
        endfunction

        function void note_transaction(logic cmd, logic [2:0] sel, logic [31:0] ret);
            int        span, fc, c;
            longint    w, ar, mom, sum, bl;
            forecast_t e;
            span = window_length < 2 ? 2 : (window_length > 64 ? 64 : window_length);
            if (cmd == wamf_pkg::CMD_PUSH)
            begin
                history[sel][wptr[sel]] = longint'($signed(ret));
                wptr[sel] = (wptr[sel] + 1) % 64;
                fill[sel] = fill[sel] < span ? fill[sel] + 1 : span;
                pushes++;
                return;
            end
            fc = factor_count < 1 ? 1 : (factor_count > 8 ? 8 : factor_count);
            w = blend_weight > 32768 ? 32768 : blend_weight;
            for (int f = 0; f < fc; f++)
            begin
                c = fill[f] < span ? fill[f] : span;
                ar = ar1_forecast(f, c);
                mom = 0;
                if (c >= wamf_pkg::MOM_MIN_SAMPLES)
                begin
                    sum = 0;
                    for (int i = 0; i < c; i++)
                        sum += sample_at(f, c, i);
                    mom = sum > 0 ? 1 : -1;
                end
                bl = (w * ar + (32768 - w) * mom * 64'sd16777216) / 32768;
                e.factor_id = 3'(f);
                e.ar1_prediction = ar[31:0];
                e.momentum_sign = mom[1:0];
                e.blended_prediction = 32'(clip32(bl));
                e.last_of_run = (f + 1 == fc);
                pending_q = {pending_q, e};
            end
        endfunction

        function void check_result(forecast_t got);
            forecast_t e;
            results++;
            if (pending_q.size() == 0)
            begin
                $error("unexpected forecast transaction for factor %0d", got.factor_id);
                mismatches++;
                return;
            end
            e = pending_q[0];
            pending_q.delete(0);
            if (got.factor_id != e.factor_id)
            begin
                $error("factor_id expected %0d actual %0d", e.factor_id, got.factor_id);
                mismatches++;
            end
            if (got.ar1_prediction != e.ar1_prediction)
            begin
                $error("ar1_prediction expected %h actual %h",
                       e.ar1_prediction, got.ar1_prediction);
                mismatches++;
            end
            if (got.momentum_sign != e.momentum_sign)
            begin
                $error("momentum_sign expected %b actual %b", e.momentum_sign, got.momentum_sign);
                mismatches++;
            end
            if (got.blended_prediction != e.blended_prediction)
            begin
                $error("blended_prediction expected %h actual %h",
                       e.blended_prediction, got.blended_prediction);
                mismatches++;
            end
            if (got.last_of_run != e.last_of_run)
            begin
                $error("last_of_run expected %0d actual %0d", e.last_of_run, got.last_of_run);
                mismatches++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 40000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [2:0]  factor_sel;
    logic [31:0] sample_return;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  factor_id;
    logic [31:0] ar1_prediction;
    logic [1:0]  momentum_sign;
    logic [31:0] blended_prediction;
    logic        last_of_run;

    forecast_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles;
    int forecasts;

    windowed_ar1_momentum_forecast_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .factor_sel(factor_sel), .sample_return(sample_return),
        .out_valid(out_valid), .out_stall(out_stall),
        .factor_id(factor_id), .ar1_prediction(ar1_prediction),
        .momentum_sign(momentum_sign), .blended_prediction(blended_prediction),
        .last_of_run(last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stall pattern
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // result monitor and watchdog
    always @(posedge clk)
    begin
        forecast_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.factor_id = factor_id;
            got.ar1_prediction = ar1_prediction;
            got.momentum_sign = momentum_sign;
            got.blended_prediction = blended_prediction;
            got.last_of_run = last_of_run;
            sb.check_result(got);
        end
        if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(logic cmd, logic [2:0] sel, logic [31:0] ret);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        factor_sel <= sel;
        sample_return <= ret;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transaction(cmd, sel, ret);
        if (cmd == wamf_pkg::CMD_FORECAST)
            forecasts++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_return();
        case ($urandom_range(9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3, 4, 5: return 32'(longint'($urandom_range(33554432)) - 64'sd16777216);
            6: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_burst(int items, int active);
        int n;
        n = 0;
        while (n < items)
        begin
            if ($urandom_range(9) == 0)
                send_item(wamf_pkg::CMD_FORECAST, 3'($urandom), $urandom);
            else
            begin
                for (int k = $urandom_range(3, 12); k > 0; k--)
                begin
                    send_item(wamf_pkg::CMD_PUSH, 3'($urandom_range(active - 1)),
                              random_return());
                    n++;
                end
                send_item(wamf_pkg::CMD_FORECAST, 3'($urandom), $urandom);
            end
            n++;
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = wamf_pkg::REG_WINDOW;
        cfg_data = '0;
        in_valid = 1'b0;
        command = wamf_pkg::CMD_PUSH;
        factor_sel = '0;
        sample_return = '0;
        send_idle_pct = 38;
        recv_idle_pct = 72;
        idle_cycles = 0;
        forecasts = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty windows, single sample, short window
        send_item(wamf_pkg::CMD_FORECAST, 3'd0, 32'h0);
        send_item(wamf_pkg::CMD_PUSH, 3'd0, 32'h7fffffff);
        send_item(wamf_pkg::CMD_PUSH, 3'd1, 32'h0);
        send_item(wamf_pkg::CMD_FORECAST, 3'd7, 32'hffffffff);
        send_item(wamf_pkg::CMD_PUSH, 3'd0, 32'h80000000);
        send_item(wamf_pkg::CMD_PUSH, 3'd1, 32'h0);
        send_item(wamf_pkg::CMD_PUSH, 3'd0, 32'h7fffffff);
        send_item(wamf_pkg::CMD_PUSH, 3'd1, 32'h0);
        send_item(wamf_pkg::CMD_PUSH, 3'd2, 32'h01000000);
        for (int i = 0; i < 4; i++)
        begin
            send_item(wamf_pkg::CMD_PUSH, 3'd0, i[0] ? 32'h80000000 : 32'h7fffffff);
            send_item(wamf_pkg::CMD_PUSH, 3'd1, 32'h0);
            send_item(wamf_pkg::CMD_PUSH, 3'd2, 32'h01000000);
        end
        send_item(wamf_pkg::CMD_FORECAST, 3'd0, 32'h0);
        // explicit hold-off until all forecasts are back
        drain();
        send_item(wamf_pkg::CMD_PUSH, 3'd7, 32'hffffffff);
        send_item(wamf_pkg::CMD_FORECAST, 3'd0, 32'h0);

        write_reg(wamf_pkg::REG_FACTORS, 16'd8);
        write_reg(wamf_pkg::REG_WINDOW, 16'd2);
        write_reg(wamf_pkg::REG_WEIGHT, 16'd0);
        random_burst(44, 8);
        write_reg(wamf_pkg::REG_WINDOW, 16'd64);
        write_reg(wamf_pkg::REG_WEIGHT, 16'd32768);
        random_burst(44, 8);

        send_idle_pct = 72;
        recv_idle_pct = 38;
        write_reg(wamf_pkg::REG_WINDOW, 16'd0);
        write_reg(wamf_pkg::REG_FACTORS, 16'd0);
        write_reg(wamf_pkg::REG_WEIGHT, 16'hffff);
        random_burst(44, 3);
        write_reg(wamf_pkg::REG_WINDOW, 16'hffff);
        write_reg(wamf_pkg::REG_FACTORS, 16'd15);
        write_reg(wamf_pkg::REG_WEIGHT, 16'd12345);
        random_burst(44, 8);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(wamf_pkg::REG_WINDOW, 16'd7);
        write_reg(wamf_pkg::REG_FACTORS, 16'd4);
        random_burst(44, 5);
        write_reg(wamf_pkg::REG_WINDOW, 16'd64);
        write_reg(wamf_pkg::REG_FACTORS, 16'd8);
        random_burst(44, 8);

        drain();
        $display("covered %0d pushes and %0d forecasts, %0d output transactions checked",
                 sb.pushes, forecasts, sb.results);
        $display("window, factor and weight registers swept through extremes and clamps");
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/wamf_pkg.sv
rtl/wamf_divider.sv
rtl/wamf_history.sv
rtl/windowed_ar1_momentum_forecast_unit.sv
dv/tb_windowed_ar1_momentum_forecast_unit.sv
